### design/ssop_pkg.sv
package ssop_pkg;

  // servo geometry and table size
  localparam int MIN_DEG       = -90;
  localparam int MAX_DEG       = 90;
  localparam int MIN_PULSE_US  = 500;
  localparam int MAX_PULSE_US  = 2500;
  localparam int SINE_ENTRIES  = 1024;
  localparam int SINE_AW       = $clog2(SINE_ENTRIES);
  localparam int QUARTER       = SINE_ENTRIES / 4;
  localparam int QAW           = SINE_AW - 2;

  // fixed constants of the pulse and duty mapping
  localparam int NEUTRAL_US    = 1500;
  localparam int PWM_RES       = 8192;
  localparam int PWM_PERIOD_US = 20000;
  localparam int SLEW_DIV      = 1000;
  localparam int SLEW_MAX_W    = 10;
  localparam int ROUND_HALF    = 16384;
  localparam int AMP_STEPS     = 7;
  localparam int PHASE_W       = 16;

  localparam int DEG_SPAN      = MAX_DEG - MIN_DEG;
  localparam int PULSE_SPAN    = MAX_PULSE_US - MIN_PULSE_US;
  localparam int ANG_W         = $clog2(DEG_SPAN + 1);

  // angle to pulse: floor(a*PULSE_SPAN/DEG_SPAN) as a*MAP_RECIP >> MAP_SHIFT
  localparam int MAP_SHIFT     = 24;
  localparam longint unsigned MAP_RECIP_L =
    ((longint'(PULSE_SPAN) << MAP_SHIFT) + DEG_SPAN - 1) / DEG_SPAN;
  localparam logic [27:0] MAP_RECIP = MAP_RECIP_L[27:0];

  // pulse to duty: floor(p*PWM_RES/PWM_PERIOD_US) as p*DUTY_RECIP >> DUTY_SHIFT
  localparam int DUTY_SHIFT    = 20;
  localparam longint unsigned DUTY_RECIP_L =
    ((longint'(PWM_RES) << DUTY_SHIFT) + PWM_PERIOD_US - 1) / PWM_PERIOD_US;
  localparam logic [18:0] DUTY_RECIP = DUTY_RECIP_L[18:0];

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // command codes
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_SET     = 2'd1;
  localparam logic [1:0] CMD_NEUTRAL = 2'd2;

  // register indexes
  localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd0;
  localparam logic [2:0] REG_PHASE_STEP    = 3'd1;
  localparam logic [2:0] REG_AMPLITUDE     = 3'd2;
  localparam logic [2:0] REG_OFFSET        = 3'd3;
  localparam logic [2:0] REG_START_PHASE   = 3'd4;
  localparam logic [2:0] REG_TRIM          = 3'd5;
  localparam logic [2:0] REG_SLEW_LIMIT    = 3'd6;
  localparam logic [2:0] REG_FLAGS         = 3'd7;

  // control flag bits
  localparam int FLAG_STOP = 0;
  localparam int FLAG_REV  = 1;

  // quarter-wave sine in unsigned Q0.15, integer Taylor series in Q30, entry k of the quarter
  function automatic logic [14:0] quarter_sine(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          q;
    int unsigned     i;
    x    = (64'(4 * k) * HALF_PI_Q30) / SINE_ENTRIES;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (i = 1; i <= 8; i++) begin
      term = (term * x2) >> 30;
      case (i)
        1: term = term / 6;
        2: term = term / 20;
        3: term = term / 42;
        4: term = term / 72;
        5: term = term / 110;
        6: term = term / 156;
        7: term = term / 210;
        8: term = term / 272;
        default: ;
      endcase
      if (i[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    q = (sum + 16384) >>> 15;
    if (q > 32767) q = 32767;
    return q[14:0];
  endfunction

  // value at the quarter point (full scale)
  localparam logic [14:0] SINE_PEAK = quarter_sine(QUARTER);

endpackage

### design/ssop_sine_rom.sv
module ssop_sine_rom (
  input  logic                               clk_i,
  input  logic [ssop_pkg::SINE_AW-1:0]       addr_i,
  output logic signed [15:0]                 data_o
);

  localparam int AW  = ssop_pkg::SINE_AW;
  localparam int QW  = ssop_pkg::QAW;

  logic [14:0]        quarter_w [ssop_pkg::QUARTER];
  logic [1:0]         quad;
  logic [QW-1:0]      rem;
  logic [QW-1:0]      qidx;
  logic [14:0]        mag;
  logic signed [15:0] data_d;
  logic signed [15:0] data_q;

  // quarter-wave table, built at elaboration
  for (genvar g = 0; g < ssop_pkg::QUARTER; g++) begin : g_quarter
    localparam logic [14:0] ENTRY = ssop_pkg::quarter_sine(g);
    assign quarter_w[g] = ENTRY;
  end

  // fold the full turn onto the quarter table
  always_comb begin
    quad = addr_i[AW-1 -: 2];
    rem  = addr_i[QW-1:0];
    qidx = quad[0] ? (~rem + 1'b1) : rem;
    if (quad[0] && (rem == '0)) begin
      mag = ssop_pkg::SINE_PEAK;
    end else begin
      mag = quarter_w[qidx];
    end
    data_d = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  // registered read
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### design/ssop_slew.sv
module ssop_slew (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [15:0]                       slew_limit_i,
  input  logic [15:0]                       elapsed_i,
  output logic                              done_o,
  output logic [ssop_pkg::SLEW_MAX_W-1:0]   max_step_o
);

  localparam int MW = ssop_pkg::SLEW_MAX_W;

  logic        busy_q, busy_d;
  logic        div_q, div_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] prod_q, prod_d;
  logic [MW-1:0] rem_q, rem_d;

  logic [16:0]   mul_sum;
  logic [MW:0]   div_tmp;
  logic          div_ge;

  // shift-add multiply then restoring divide by the ms-per-second constant
  always_comb begin
    mul_sum = {1'b0, prod_q[31:16]} + (prod_q[0] ? {1'b0, slew_limit_i} : 17'd0);
    div_tmp = {rem_q, prod_q[31]};
    div_ge  = (div_tmp >= (MW+1)'(ssop_pkg::SLEW_DIV));

    busy_d = busy_q;
    div_d  = div_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    prod_d = prod_q;
    rem_d  = rem_q;

    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      div_d  = 1'b0;
      cnt_d  = '0;
      prod_d = {16'd0, elapsed_i};
    end else if (busy_q && !div_q) begin
      // one multiplier bit per cycle, low bits first
      prod_d = {mul_sum, prod_q[15:1]};
      cnt_d  = cnt_q + 5'd1;
      if (cnt_q == 5'd15) begin
        div_d = 1'b1;
        cnt_d = '0;
        rem_d = '0;
      end
    end else if (busy_q) begin
      // one quotient bit per cycle, high bits first
      rem_d  = div_ge ? MW'(div_tmp - (MW+1)'(ssop_pkg::SLEW_DIV)) : div_tmp[MW-1:0];
      prod_d = {prod_q[30:0], div_ge};
      cnt_d  = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      div_q  <= div_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  // quotient saturated to the step width
  assign max_step_o = (|prod_q[31:MW]) ? '1 : prod_q[MW-1:0];
  assign done_o     = done_q;

endmodule

### design/servo_sine_oscillator_pwm_top.sv
// Steps: neutral goes straight to the duty step; set position passes slew, map, pulse and
// duty; a sampled tick first runs the bit-serial phase adders, ROM read, amplitude multiply
// and rounding (when stopped, it holds the last position instead); a tick without a sample
// only advances the counters. An active slew limit adds a 16-bit shift-add multiply followed
// by a 32-step restoring divide by 1000. One item at a time, the next taken the cycle after
// the word is loaded; a finished word waits in the output register while the next is taken.
// Reset: asynchronous active low; control registers reset (counters to 0), payload does not.
module servo_sine_oscillator_pwm_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic signed [8:0] target_position_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [12:0]       duty_word_o,
  output logic [11:0]       pulse_us_o,
  output logic signed [8:0] commanded_deg_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);

  localparam int MW = ssop_pkg::SLEW_MAX_W;
  localparam int AW = ssop_pkg::ANG_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PHASE  = 4'd1;
  localparam logic [3:0] S_ROM    = 4'd2;
  localparam logic [3:0] S_LOAD   = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_ROUND  = 4'd5;
  localparam logic [3:0] S_SLEW   = 4'd6;
  localparam logic [3:0] S_WAIT   = 4'd7;
  localparam logic [3:0] S_MAP    = 4'd8;
  localparam logic [3:0] S_PULSE  = 4'd9;
  localparam logic [3:0] S_PULSE2 = 4'd10;
  localparam logic [3:0] S_DUTY   = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  localparam logic signed [9:0] MAX_ANG = 10'(ssop_pkg::MAX_DEG);
  localparam logic signed [9:0] MIN_ANG = 10'(ssop_pkg::MIN_DEG);
  localparam logic [AW-1:0]     ANG_TOP = AW'(ssop_pkg::DEG_SPAN);

  // configuration registers
  logic [9:0]        sample_period_q, sample_period_d;
  logic [15:0]       phase_step_q, phase_step_d;
  logic [6:0]        amplitude_q, amplitude_d;
  logic signed [7:0] offset_q, offset_d;
  logic [15:0]       start_phase_q, start_phase_d;
  logic signed [7:0] trim_q, trim_d;
  logic [15:0]       slew_limit_q, slew_limit_d;
  logic [1:0]        flags_q, flags_d;

  // control and architectural state
  logic [3:0]        state_q, state_d;
  logic [3:0]        bit_cnt_q, bit_cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [15:0]       ms_sample_q, ms_sample_d;
  logic [15:0]       ms_write_q, ms_write_d;
  logic [15:0]       phase_acc_q, phase_acc_d;
  logic signed [8:0] last_pos_q, last_pos_d;

  // working registers
  logic [15:0]        ph_q, ph_d;
  logic               c1_q, c1_d;
  logic               c2_q, c2_d;
  logic signed [9:0]  pos_q, pos_d;
  logic signed [23:0] acc_q, acc_d;
  logic signed [23:0] mcand_q, mcand_d;
  logic [6:0]         mplier_q, mplier_d;
  logic signed [8:0]  cmd_deg_q, cmd_deg_d;
  logic [AW-1:0]      ang_q, ang_d;
  logic [35:0]        pmul_q, pmul_d;
  logic [11:0]        pulse_q, pulse_d;
  logic [30:0]        dmul_q, dmul_d;
  logic [12:0]        duty_out_q, duty_out_d;
  logic [11:0]        pulse_out_q, pulse_out_d;
  logic signed [8:0]  deg_out_q, deg_out_d;

  // combinational helpers
  logic [15:0]        ms_s_inc, ms_w_inc;
  logic               b_step, b_start, s1, s2;
  logic [23:0]        mag, rsum;
  logic signed [9:0]  rpos;
  logic signed [10:0] diff, maxd_s, last_x;
  logic signed [9:0]  angle;
  logic signed [8:0]  pos9;
  logic               slew_start;
  logic               slew_done;
  logic [MW-1:0]      max_step;
  logic signed [15:0] rom_data;

  ssop_sine_rom u_rom (
    .clk_i  (clk_i),
    .addr_i (ph_q[15 -: ssop_pkg::SINE_AW]),
    .data_o (rom_data)
  );

  ssop_slew u_slew (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (slew_start),
    .slew_limit_i (slew_limit_q),
    .elapsed_i    (ms_write_q),
    .done_o       (slew_done),
    .max_step_o   (max_step)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);

  // sequencer and datapath
  always_comb begin
    sample_period_d = sample_period_q;
    phase_step_d    = phase_step_q;
    amplitude_d     = amplitude_q;
    offset_d        = offset_q;
    start_phase_d   = start_phase_q;
    trim_d          = trim_q;
    slew_limit_d    = slew_limit_q;
    flags_d         = flags_q;
    state_d         = state_q;
    bit_cnt_d       = bit_cnt_q;
    out_valid_d     = out_valid_q;
    ms_sample_d     = ms_sample_q;
    ms_write_d      = ms_write_q;
    phase_acc_d     = phase_acc_q;
    last_pos_d      = last_pos_q;
    ph_d            = ph_q;
    c1_d            = c1_q;
    c2_d            = c2_q;
    pos_d           = pos_q;
    acc_d           = acc_q;
    mcand_d         = mcand_q;
    mplier_d        = mplier_q;
    cmd_deg_d       = cmd_deg_q;
    ang_d           = ang_q;
    pmul_d          = pmul_q;
    pulse_d         = pulse_q;
    dmul_d          = dmul_q;
    duty_out_d      = duty_out_q;
    pulse_out_d     = pulse_out_q;
    deg_out_d       = deg_out_q;
    slew_start      = 1'b0;

    ms_s_inc = (ms_sample_q == 16'hFFFF) ? ms_sample_q : ms_sample_q + 16'd1;
    ms_w_inc = (ms_write_q == 16'hFFFF) ? ms_write_q : ms_write_q + 16'd1;

    b_step  = phase_step_q[bit_cnt_q];
    b_start = start_phase_q[bit_cnt_q];
    s1      = phase_acc_q[0] ^ b_step ^ c1_q;
    s2      = s1 ^ b_start ^ c2_q;

    mag  = acc_q[23] ? -acc_q : acc_q;
    rsum = mag + 24'(ssop_pkg::ROUND_HALF);
    rpos = acc_q[23] ? -$signed({1'b0, rsum[23:15]}) : $signed({1'b0, rsum[23:15]});
    if (flags_q[ssop_pkg::FLAG_REV]) rpos = -rpos;

    last_x = {{2{last_pos_q[8]}}, last_pos_q};
    diff   = {pos_q[9], pos_q} - last_x;
    maxd_s = $signed({1'b0, max_step});

    pos9  = pos_q[8:0];
    angle = {pos9[8], pos9} + {{2{trim_q[7]}}, trim_q};
    if (angle > MAX_ANG) angle = MAX_ANG;
    if (angle < MIN_ANG) angle = MIN_ANG;

    // register writes
    if (cfg_valid_i) begin
      case (cfg_index_i)
        ssop_pkg::REG_SAMPLE_PERIOD: sample_period_d = cfg_data_i[9:0];
        ssop_pkg::REG_PHASE_STEP:    phase_step_d    = cfg_data_i;
        ssop_pkg::REG_AMPLITUDE:     amplitude_d     = cfg_data_i[6:0];
        ssop_pkg::REG_OFFSET:        offset_d        = cfg_data_i[7:0];
        ssop_pkg::REG_START_PHASE:   start_phase_d   = cfg_data_i;
        ssop_pkg::REG_TRIM:          trim_d          = cfg_data_i[7:0];
        ssop_pkg::REG_SLEW_LIMIT:    slew_limit_d    = cfg_data_i;
        ssop_pkg::REG_FLAGS:         flags_d         = cfg_data_i[1:0];
        default: ;
      endcase
    end

    // output word taken
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (cmd_i)
            ssop_pkg::CMD_TICK: begin
              ms_sample_d = ms_s_inc;
              ms_write_d  = ms_w_inc;
              if (ms_s_inc > {6'd0, sample_period_q}) begin
                ms_sample_d = '0;
                if (flags_q[ssop_pkg::FLAG_STOP]) begin
                  pos_d   = {last_pos_q[8], last_pos_q};
                  state_d = S_SLEW;
                end else begin
                  bit_cnt_d = '0;
                  c1_d      = 1'b0;
                  c2_d      = 1'b0;
                  state_d   = S_PHASE;
                end
              end
            end
            ssop_pkg::CMD_SET: begin
              pos_d   = {target_position_i[8], target_position_i};
              state_d = S_SLEW;
            end
            ssop_pkg::CMD_NEUTRAL: begin
              pulse_d   = 12'(ssop_pkg::NEUTRAL_US) + {{4{trim_q[7]}}, trim_q};
              cmd_deg_d = last_pos_q;
              state_d   = S_DUTY;
            end
            default: ;
          endcase
        end
      end
      // two bit-serial adders: accumulator advance, then start phase
      S_PHASE: begin
        phase_acc_d = {s1, phase_acc_q[15:1]};
        c1_d        = (phase_acc_q[0] & b_step) | (phase_acc_q[0] & c1_q) | (b_step & c1_q);
        ph_d        = {s2, ph_q[15:1]};
        c2_d        = (s1 & b_start) | (s1 & c2_q) | (b_start & c2_q);
        bit_cnt_d   = bit_cnt_q + 4'd1;
        if (bit_cnt_q == 4'(ssop_pkg::PHASE_W - 1)) state_d = S_ROM;
      end
      S_ROM: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        mcand_d   = {{8{rom_data[15]}}, rom_data};
        acc_d     = {offset_q[7], offset_q, 15'd0};
        mplier_d  = amplitude_q;
        bit_cnt_d = '0;
        state_d   = S_MUL;
      end
      // amplitude times sine, one amplitude bit per cycle
      S_MUL: begin
        if (mplier_q[0]) acc_d = acc_q + mcand_q;
        mcand_d   = mcand_q <<< 1;
        mplier_d  = mplier_q >> 1;
        bit_cnt_d = bit_cnt_q + 4'd1;
        if (bit_cnt_q == 4'(ssop_pkg::AMP_STEPS - 1)) state_d = S_ROUND;
      end
      // round half away from zero to whole degrees
      S_ROUND: begin
        pos_d   = rpos;
        state_d = S_SLEW;
      end
      S_SLEW: begin
        state_d = S_MAP;
        if (slew_limit_q != '0) begin
          ms_write_d = '0;
          if (ms_write_q != '0) begin
            slew_start = 1'b1;
            state_d    = S_WAIT;
          end
        end
      end
      // hold the step to the allowed distance from the last position
      S_WAIT: begin
        if (slew_done) begin
          if (diff > maxd_s) begin
            pos_d = 10'(last_x + maxd_s);
          end else if (-diff > maxd_s) begin
            pos_d = 10'(last_x - maxd_s);
          end
          state_d = S_MAP;
        end
      end
      S_MAP: begin
        last_pos_d = pos9;
        cmd_deg_d  = pos9;
        ang_d      = AW'(angle - MIN_ANG);
        state_d    = S_PULSE;
      end
      S_PULSE: begin
        pmul_d  = 36'(ang_q) * 36'(ssop_pkg::MAP_RECIP);
        state_d = S_PULSE2;
      end
      S_PULSE2: begin
        pulse_d = 12'(pmul_q >> ssop_pkg::MAP_SHIFT) + 12'(ssop_pkg::MIN_PULSE_US);
        state_d = S_DUTY;
      end
      S_DUTY: begin
        dmul_d  = 31'(pulse_q) * 31'(ssop_pkg::DUTY_RECIP);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          duty_out_d  = 13'(dmul_q >> ssop_pkg::DUTY_SHIFT);
          pulse_out_d = pulse_q;
          deg_out_d   = cmd_deg_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_period_q <= 10'd30;
      phase_step_q    <= 16'd992;
      amplitude_q     <= 7'd45;
      offset_q        <= '0;
      start_phase_q   <= '0;
      trim_q          <= '0;
      slew_limit_q    <= '0;
      flags_q         <= '0;
      state_q         <= S_IDLE;
      bit_cnt_q       <= '0;
      out_valid_q     <= 1'b0;
      ms_sample_q     <= '0;
      ms_write_q      <= '0;
      phase_acc_q     <= '0;
      last_pos_q      <= '0;
    end else begin
      sample_period_q <= sample_period_d;
      phase_step_q    <= phase_step_d;
      amplitude_q     <= amplitude_d;
      offset_q        <= offset_d;
      start_phase_q   <= start_phase_d;
      trim_q          <= trim_d;
      slew_limit_q    <= slew_limit_d;
      flags_q         <= flags_d;
      state_q         <= state_d;
      bit_cnt_q       <= bit_cnt_d;
      out_valid_q     <= out_valid_d;
      ms_sample_q     <= ms_sample_d;
      ms_write_q      <= ms_write_d;
      phase_acc_q     <= phase_acc_d;
      last_pos_q      <= last_pos_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    ph_q        <= ph_d;
    c1_q        <= c1_d;
    c2_q        <= c2_d;
    pos_q       <= pos_d;
    acc_q       <= acc_d;
    mcand_q     <= mcand_d;
    mplier_q    <= mplier_d;
    cmd_deg_q   <= cmd_deg_d;
    ang_q       <= ang_d;
    pmul_q      <= pmul_d;
    pulse_q     <= pulse_d;
    dmul_q      <= dmul_d;
    duty_out_q  <= duty_out_d;
    pulse_out_q <= pulse_out_d;
    deg_out_q   <= deg_out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign duty_word_o     = duty_out_q;
  assign pulse_us_o      = pulse_out_q;
  assign commanded_deg_o = deg_out_q;

`ifndef SYNTHESIS
  // a new word only comes from the output step of the sequencer
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("output word appeared outside the output step");

  // the slew unit only finishes while the sequencer waits for it
  a_slew_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slew_done |-> state_q == S_WAIT)
    else $error("slew unit finished while not awaited");

  // a freshly loaded word reports the position now held
  a_deg_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == S_OUT && state_q == S_IDLE) |-> commanded_deg_o == last_pos_q)
    else $error("commanded angle differs from held position");

  // clamped angle stays within the mapping span
  a_ang_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PULSE |-> ang_q <= ANG_TOP)
    else $error("angle index out of range");
`endif

endmodule
